### rtl/tte_pkg.sv
// Shared types and constants for the text terminal character engine.
// Used by every module in rtl/; depends on nothing.
package tte_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 4;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int ROWT_W = ROW_W + 1;
    localparam int COLT_W = COL_W + 1;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0700;

    // row = (index * DIV_RECIP) >> DIV_SHIFT, then one correction step
    localparam int DIV_SHIFT = 17;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / COLUMNS + 1;
    localparam int PROD_W    = IDX_W + $clog2(DIV_RECIP + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ATTRIBUTE = 1'b0;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        OP_READ,
        OP_IGNORE,
        OP_LF,
        OP_CR,
        OP_TAB,
        OP_BS,
        OP_PUT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  char_byte;
        logic [IDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_RD_SPLIT,
        ST_RD_ADDR,
        ST_EMIT
    } t_state;

endpackage

### rtl/tte_front.sv
// Front stage: accepts requests and classifies the byte into an operation.
// Uses tte_pkg; feeds tte_queue.
module tte_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [tte_pkg::CHAR_W-1:0] i_char_byte,
    input  logic [tte_pkg::IDX_W-1:0]  i_read_index,
    input  tte_pkg::t_back_status      i_back_status,
    input  tte_pkg::t_q_status         i_q_status,
    output logic                       o_push,
    output tte_pkg::t_item             o_item
);

    logic            r_valid;
    logic            n_valid;
    tte_pkg::t_item  r_item;
    tte_pkg::t_item  n_item;
    logic            accept;

    always_comb begin
        o_push     = r_valid && !i_q_status.full;
        o_in_stall = i_back_status.clearing || (r_valid && i_q_status.full);
        accept     = i_in_valid && !o_in_stall;
        n_valid    = accept ? 1'b1 : (o_push ? 1'b0 : r_valid);

        n_item            = r_item;
        if (accept) begin
            n_item.char_byte  = i_char_byte;
            n_item.read_index = i_read_index;
            if (i_cmd == tte_pkg::CMD_READ) begin
                n_item.op = tte_pkg::OP_READ;
            end else begin
                unique case (i_char_byte) inside
                    tte_pkg::CH_NUL, tte_pkg::CH_FF,
                    tte_pkg::CH_VT, tte_pkg::CH_BEL: n_item.op = tte_pkg::OP_IGNORE;
                    tte_pkg::CH_LF:                  n_item.op = tte_pkg::OP_LF;
                    tte_pkg::CH_CR:                  n_item.op = tte_pkg::OP_CR;
                    tte_pkg::CH_TAB:                 n_item.op = tte_pkg::OP_TAB;
                    tte_pkg::CH_BS:                  n_item.op = tte_pkg::OP_BS;
                    default:                         n_item.op = tte_pkg::OP_PUT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

### rtl/tte_queue.sv
// Short request queue between the front and back stages.
// Uses tte_pkg for the entry type and depth.
module tte_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tte_pkg::t_item     i_item,
    input  logic               i_pop,
    output tte_pkg::t_item     o_head,
    output tte_pkg::t_q_status o_status
);

    tte_pkg::t_item                r_slot [tte_pkg::QUEUE_DEPTH];
    logic [tte_pkg::QUEUE_AW-1:0]  r_wptr;
    logic [tte_pkg::QUEUE_AW-1:0]  r_rptr;
    logic [tte_pkg::QUEUE_AW:0]    r_count;

    always_comb begin
        o_status.full  = (r_count == (tte_pkg::QUEUE_AW + 1)'(tte_pkg::QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        o_head         = r_slot[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

### rtl/tte_back.sv
// Back stage: runs each request against the screen memory and the cursor.
// Screen is a ring of rows; scrolling advances the top row and clears one line.
// Uses tte_pkg; takes requests from tte_queue.
module tte_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tte_pkg::ATTR_W-1:0]  i_attr,
    input  tte_pkg::t_q_status          i_q_status,
    input  tte_pkg::t_item              i_q_head,
    output logic                        o_pop,
    output tte_pkg::t_back_status       o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tte_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tte_pkg::COL_W-1:0]   o_cursor_column,
    output logic [tte_pkg::IDX_W-1:0]   o_cursor_index,
    output logic [tte_pkg::CELL_W-1:0]  o_cell_data,
    output logic                        o_text_changed,
    output logic                        o_cursor_changed
);

    logic [tte_pkg::CELL_W-1:0] r_mem [tte_pkg::CELL_COUNT];
    logic [tte_pkg::CELL_W-1:0] r_rdata;

    tte_pkg::t_state              r_state, n_state;
    logic [tte_pkg::ROW_W-1:0]    r_row, n_row;
    logic [tte_pkg::COL_W-1:0]    r_col, n_col;
    logic [tte_pkg::ROW_W-1:0]    r_base, n_base;
    logic [tte_pkg::IDX_W-1:0]    r_sweep, n_sweep;
    logic [tte_pkg::IDX_W-1:0]    r_sweep_end, n_sweep_end;
    logic                         r_out_valid, n_out_valid;

    tte_pkg::t_item               r_item, n_item;
    logic                         r_text, n_text;
    logic                         r_cur, n_cur;
    logic [tte_pkg::ROW_W-1:0]    r_rq, n_rq;
    logic [tte_pkg::COL_W-1:0]    r_rcol, n_rcol;
    logic                         r_rin, n_rin;
    logic [tte_pkg::ROW_W-1:0]    r_out_row, n_out_row;
    logic [tte_pkg::COL_W-1:0]    r_out_col, n_out_col;
    logic [tte_pkg::IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [tte_pkg::CELL_W-1:0]   r_out_cell, n_out_cell;
    logic                         r_out_text, n_out_text;
    logic                         r_out_cur, n_out_cur;

    logic                         mem_we;
    logic                         mem_re;
    logic [tte_pkg::IDX_W-1:0]    mem_addr;
    logic [tte_pkg::CELL_W-1:0]   mem_wdata;

    always_comb begin
        logic [tte_pkg::COLT_W-1:0]  col_t;
        logic [tte_pkg::ROWT_W-1:0]  row_t;
        logic [tte_pkg::COL_W-1:0]   wcol;
        logic [tte_pkg::COL_W-1:0]   tab_rem;
        logic [tte_pkg::ROWT_W-1:0]  cur_phys;
        logic [tte_pkg::ROWT_W-1:0]  rd_phys;
        logic [tte_pkg::IDX_W-1:0]   rem;
        logic [tte_pkg::PROD_W-1:0]  prod;
        logic [tte_pkg::CELL_W-1:0]  blank;
        logic                        we;
        logic [tte_pkg::CELL_W-1:0]  wdata;
        logic                        text;
        logic                        cur;
        logic                        scroll;
        logic                        emit_ok;

        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_sweep     = r_sweep;
        n_sweep_end = r_sweep_end;
        n_item      = r_item;
        n_text      = r_text;
        n_cur       = r_cur;
        n_rq        = r_rq;
        n_rcol      = r_rcol;
        n_rin       = r_rin;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_idx   = r_out_idx;
        n_out_cell  = r_out_cell;
        n_out_text  = r_out_text;
        n_out_cur   = r_out_cur;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_sweep;
        mem_wdata   = tte_pkg::CELL_RESET;

        blank   = {i_attr, {tte_pkg::CHAR_W{1'b0}}};
        emit_ok = !r_out_valid || !i_out_stall;

        // put: next cursor, cell write and flags
        col_t   = {1'b0, r_col};
        row_t   = {1'b0, r_row};
        wcol    = r_col;
        tab_rem = tte_pkg::COL_W'(r_col % tte_pkg::COL_W'(tte_pkg::TAB_STOP));
        we      = 1'b0;
        wdata   = blank;
        text    = 1'b0;
        cur     = 1'b0;
        scroll  = 1'b0;
        case (r_item.op)
            tte_pkg::OP_LF: begin
                row_t = row_t + 1'b1;
                col_t = '0;
                cur   = 1'b1;
            end
            tte_pkg::OP_CR: begin
                col_t = '0;
                cur   = 1'b1;
            end
            tte_pkg::OP_TAB: begin
                if (tab_rem != '0) begin
                    col_t = col_t + tte_pkg::COLT_W'(tte_pkg::TAB_STOP)
                          - {1'b0, tab_rem};
                    cur   = 1'b1;
                end
            end
            tte_pkg::OP_BS: begin
                if (r_col != '0) begin
                    col_t = col_t - 1'b1;
                    wcol  = r_col - 1'b1;
                    cur   = 1'b1;
                end
                we   = 1'b1;
                text = 1'b1;
            end
            tte_pkg::OP_PUT: begin
                we    = 1'b1;
                wdata = {i_attr, r_item.char_byte};
                col_t = col_t + 1'b1;
                text  = 1'b1;
                cur   = 1'b1;
            end
            default: begin
            end
        endcase
        if (col_t >= tte_pkg::COLT_W'(tte_pkg::COLUMNS)) begin
            col_t = '0;
            row_t = row_t + 1'b1;
            cur   = 1'b1;
        end
        if (row_t >= tte_pkg::ROWT_W'(tte_pkg::ROWS)) begin
            row_t  = tte_pkg::ROWT_W'(tte_pkg::ROWS - 1);
            text   = 1'b1;
            cur    = 1'b1;
            scroll = 1'b1;
        end

        cur_phys = {1'b0, r_row} + {1'b0, r_base};
        if (cur_phys >= tte_pkg::ROWT_W'(tte_pkg::ROWS)) begin
            cur_phys = cur_phys - tte_pkg::ROWT_W'(tte_pkg::ROWS);
        end

        rd_phys = {1'b0, r_rq} + {1'b0, r_base};
        if (rd_phys >= tte_pkg::ROWT_W'(tte_pkg::ROWS)) begin
            rd_phys = rd_phys - tte_pkg::ROWT_W'(tte_pkg::ROWS);
        end

        prod = tte_pkg::PROD_W'(r_item.read_index) * tte_pkg::PROD_W'(tte_pkg::DIV_RECIP);
        rem  = r_item.read_index
             - tte_pkg::IDX_W'(r_rq) * tte_pkg::IDX_W'(tte_pkg::COLUMNS);

        unique case (r_state)
            tte_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_sweep;
                mem_wdata = tte_pkg::CELL_RESET;
                if (r_sweep == tte_pkg::IDX_W'(tte_pkg::CELL_COUNT - 1)) begin
                    n_state = tte_pkg::ST_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            tte_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_item  = i_q_head;
                    n_state = tte_pkg::ST_EXEC;
                end
            end
            tte_pkg::ST_EXEC: begin
                if (r_item.op == tte_pkg::OP_READ) begin
                    n_rq    = tte_pkg::ROW_W'(prod >> tte_pkg::DIV_SHIFT);
                    n_text  = 1'b0;
                    n_cur   = 1'b0;
                    n_state = tte_pkg::ST_RD_SPLIT;
                end else begin
                    mem_we    = we;
                    mem_addr  = tte_pkg::IDX_W'(cur_phys) * tte_pkg::IDX_W'(tte_pkg::COLUMNS)
                              + tte_pkg::IDX_W'(wcol);
                    mem_wdata = wdata;
                    n_row     = row_t[tte_pkg::ROW_W-1:0];
                    n_col     = col_t[tte_pkg::COL_W-1:0];
                    n_text    = text;
                    n_cur     = cur;
                    if (scroll) begin
                        // old top row becomes the new bottom line
                        if (r_base == tte_pkg::ROW_W'(tte_pkg::ROWS - 1)) begin
                            n_base = '0;
                        end else begin
                            n_base = r_base + 1'b1;
                        end
                        n_sweep     = tte_pkg::IDX_W'(r_base) * tte_pkg::IDX_W'(tte_pkg::COLUMNS);
                        n_sweep_end = n_sweep + tte_pkg::IDX_W'(tte_pkg::COLUMNS - 1);
                        n_state     = tte_pkg::ST_SCROLL;
                    end else begin
                        n_state = tte_pkg::ST_EMIT;
                    end
                end
            end
            tte_pkg::ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_addr  = r_sweep;
                mem_wdata = blank;
                if (r_sweep == r_sweep_end) begin
                    n_state = tte_pkg::ST_EMIT;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            tte_pkg::ST_RD_SPLIT: begin
                if (rem >= tte_pkg::IDX_W'(tte_pkg::COLUMNS)) begin
                    n_rq   = r_rq + 1'b1;
                    n_rcol = tte_pkg::COL_W'(rem - tte_pkg::IDX_W'(tte_pkg::COLUMNS));
                end else begin
                    n_rcol = tte_pkg::COL_W'(rem);
                end
                n_rin   = r_item.read_index < tte_pkg::IDX_W'(tte_pkg::CELL_COUNT);
                n_state = tte_pkg::ST_RD_ADDR;
            end
            tte_pkg::ST_RD_ADDR: begin
                mem_re   = r_rin;
                mem_addr = tte_pkg::IDX_W'(rd_phys) * tte_pkg::IDX_W'(tte_pkg::COLUMNS)
                         + tte_pkg::IDX_W'(r_rcol);
                n_state  = tte_pkg::ST_EMIT;
            end
            tte_pkg::ST_EMIT: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_out_idx   = tte_pkg::IDX_W'(r_row) * tte_pkg::IDX_W'(tte_pkg::COLUMNS)
                                + tte_pkg::IDX_W'(r_col);
                    n_out_cell  = (r_item.op == tte_pkg::OP_READ && r_rin) ? r_rdata : '0;
                    n_out_text  = r_text;
                    n_out_cur   = r_cur;
                    if (!i_q_status.empty) begin
                        o_pop   = 1'b1;
                        n_item  = i_q_head;
                        n_state = tte_pkg::ST_EXEC;
                    end else begin
                        n_state = tte_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tte_pkg::ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_sweep     <= '0;
            r_sweep_end <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_sweep     <= n_sweep;
            r_sweep_end <= n_sweep_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_text     <= n_text;
        r_cur      <= n_cur;
        r_rq       <= n_rq;
        r_rcol     <= n_rcol;
        r_rin      <= n_rin;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_idx  <= n_out_idx;
        r_out_cell <= n_out_cell;
        r_out_text <= n_out_text;
        r_out_cur  <= n_out_cur;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    assign o_status.clearing = (r_state == tte_pkg::ST_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_column   = r_out_col;
    assign o_cursor_index    = r_out_idx;
    assign o_cell_data       = r_out_cell;
    assign o_text_changed    = r_out_text;
    assign o_cursor_changed  = r_out_cur;

endmodule

### rtl/text_terminal_char_engine_core.sv
// Text terminal character engine: front classifier, request queue, back executor.
// Requests run one at a time in the back stage; a scroll clears one line
// in the screen memory, one cell per cycle over its single port.
// After reset a pass writes all 2000 cells to 0x0700; requests stall until done.
module text_terminal_char_engine_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [tte_pkg::CHAR_W-1:0]       i_char_byte,
    input  logic [tte_pkg::IDX_W-1:0]        i_read_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tte_pkg::ROW_W-1:0]        o_cursor_row,
    output logic [tte_pkg::COL_W-1:0]        o_cursor_column,
    output logic [tte_pkg::IDX_W-1:0]        o_cursor_index,
    output logic [tte_pkg::CELL_W-1:0]       o_cell_data,
    output logic                             o_text_changed,
    output logic                             o_cursor_changed,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tte_pkg::PADDR_W-1:0]      paddr,
    input  logic [tte_pkg::PDATA_W-1:0]      pwdata,
    output logic [tte_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    logic [tte_pkg::ATTR_W-1:0] r_attr;
    logic                       reg_index;

    tte_pkg::t_item        push_item;
    tte_pkg::t_item        head_item;
    tte_pkg::t_q_status    q_status;
    tte_pkg::t_back_status back_status;
    logic                  push;
    logic                  pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];

    always_comb begin
        prdata = '0;
        if (reg_index == tte_pkg::REG_ATTRIBUTE) begin
            prdata = tte_pkg::PDATA_W'(r_attr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tte_pkg::ATTR_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_index == tte_pkg::REG_ATTRIBUTE) begin
            r_attr <= pwdata[tte_pkg::ATTR_W-1:0];
        end
    end

    tte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_char_byte   (i_char_byte),
        .i_read_index  (i_read_index),
        .i_back_status (back_status),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_item        (push_item)
    );

    tte_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    tte_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_attr           (r_attr),
        .i_q_status       (q_status),
        .i_q_head         (head_item),
        .o_pop            (pop),
        .o_status         (back_status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_index   (o_cursor_index),
        .o_cell_data      (o_cell_data),
        .o_text_changed   (o_text_changed),
        .o_cursor_changed (o_cursor_changed)
    );

endmodule

### verif/tb_text_terminal_char_engine_core.sv
// Self-checking testbench for text_terminal_char_engine_core: directed and random
// put/read requests against a behavioral screen/cursor mirror, APB attribute writes.
// Depends on rtl/tte_pkg.sv and rtl/text_terminal_char_engine_core.sv.
module tb_text_terminal_char_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 120;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * REG_ATTRIBUTE);

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [IDX_W-1:0]  index;
        logic [CELL_W-1:0] cell_data;
        logic              text;
        logic              cursor;
    } t_term_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_cmd;
    logic [CHAR_W-1:0]   i_char_byte;
    logic [IDX_W-1:0]    i_read_index;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [ROW_W-1:0]    o_cursor_row;
    logic [COL_W-1:0]    o_cursor_column;
    logic [IDX_W-1:0]    o_cursor_index;
    logic [CELL_W-1:0]   o_cell_data;
    logic                o_text_changed;
    logic                o_cursor_changed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [CELL_W-1:0]   screen_mirror [CELL_COUNT];
    int                  cur_row;
    int                  cur_col;
    logic [ATTR_W-1:0]   attr_mirror;
    t_term_outcome       pending_outcomes [$];
    int                  mismatch_count;
    int                  cycle_count;
    bit                  quiet_mode;
    bit                  hold_off_req;

    text_terminal_char_engine_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_char_byte      (i_char_byte),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_index   (o_cursor_index),
        .o_cell_data      (o_cell_data),
        .o_text_changed   (o_text_changed),
        .o_cursor_changed (o_cursor_changed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_text_terminal_char_engine_core: FAIL");
            $finish;
        end
    end

    function automatic t_term_outcome terminal_advance(input logic cmd,
                                                       input logic [CHAR_W-1:0] ch,
                                                       input logic [IDX_W-1:0] ridx);
        t_term_outcome r;
        int            rem;
        r = '0;
        if (cmd == CMD_READ) begin
            if (ridx < CELL_COUNT) r.cell_data = screen_mirror[ridx];
        end else begin
            case (ch) inside
                CH_NUL, CH_FF, CH_VT, CH_BEL: ;
                CH_LF: begin
                    cur_row++;
                    cur_col  = 0;
                    r.cursor = 1'b1;
                end
                CH_CR: begin
                    cur_col  = 0;
                    r.cursor = 1'b1;
                end
                CH_TAB: begin
                    rem = cur_col % TAB_STOP;
                    if (rem != 0) begin
                        cur_col += TAB_STOP - rem;
                        r.cursor = 1'b1;
                    end
                end
                CH_BS: begin
                    if (cur_col > 0) begin
                        cur_col--;
                        r.cursor = 1'b1;
                    end
                    screen_mirror[cur_row * COLUMNS + cur_col] = {attr_mirror, 8'h00};
                    r.text = 1'b1;
                end
                default: begin
                    screen_mirror[cur_row * COLUMNS + cur_col] = {attr_mirror, ch};
                    cur_col++;
                    r.text   = 1'b1;
                    r.cursor = 1'b1;
                end
            endcase
            if (cur_col >= COLUMNS) begin
                cur_col  = 0;
                cur_row++;
                r.cursor = 1'b1;
            end
            if (cur_row >= ROWS) begin
                for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                    screen_mirror[i] = screen_mirror[i + COLUMNS];
                for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                    screen_mirror[i] = {attr_mirror, 8'h00};
                cur_row  = ROWS - 1;
                r.text   = 1'b1;
                r.cursor = 1'b1;
            end
        end
        r.row    = ROW_W'(cur_row);
        r.column = COL_W'(cur_col);
        r.index  = IDX_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_term_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual row %0d col %0d",
                         $time, o_cursor_row, o_cursor_column);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("cursor_row", want.row, o_cursor_row);
                check_field("cursor_column", want.column, o_cursor_column);
                check_field("cursor_index", want.index, o_cursor_index);
                check_field("cell_data", want.cell_data, o_cell_data);
                check_field("text_changed", want.text, o_text_changed);
                check_field("cursor_changed", want.cursor, o_cursor_changed);
            end
        end
    end

    initial begin : out_stall_drive
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                i_out_stall  <= 1'b0;
                hold_off_req = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] ridx);
        int gap;
        @(negedge i_clk);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_char_byte  <= ch;
        i_read_index <= ridx;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(terminal_advance(cmd, ch, ridx));
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_request(CMD_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] ridx);
        send_request(CMD_READ, CHAR_W'($urandom_range(0, 255)), ridx);
    endtask

    task automatic drain_outcomes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        attr_mirror = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("attribute readback", PDATA_W'(value), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_screen();
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(CELL_COUNT - 1));
        read_cell(IDX_W'(CELL_COUNT));
        read_cell('1);
    endtask

    task automatic test_control_codes();
        put_char(CH_NUL);
        put_char(CH_FF);
        put_char(CH_VT);
        put_char(CH_BEL);
        put_char(CH_CR);
        put_char(CH_TAB);
        put_char(CH_BS);
        put_char(8'h41);
        put_char(CH_TAB);
        put_char(8'hFF);
        put_char(8'h80);
        put_char(CH_BS);
        put_char(CH_LF);
        put_char(8'h01);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(4));
    endtask

    task automatic test_attribute_extremes();
        drain_outcomes();
        set_attribute(8'h00);
        put_char(8'h7F);
        read_cell(IDX_W'(cur_row * COLUMNS + cur_col - 1));
        drain_outcomes();
        set_attribute(8'hFF);
        put_char(8'h20);
        put_char(CH_BS);
        read_cell(IDX_W'(cur_row * COLUMNS + cur_col));
    endtask

    task automatic send_random_stream(input int count);
        int pick;
        int last;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            last = cur_row * COLUMNS + cur_col;
            if (pick < 55) begin
                put_char(CHAR_W'($urandom_range(0, 255)));
            end else if (pick < 65) begin
                put_char(CH_LF);
            end else if (pick < 80) begin
                case ($urandom_range(0, 7))
                    0: put_char(CH_NUL);
                    1: put_char(CH_FF);
                    2: put_char(CH_VT);
                    3: put_char(CH_BEL);
                    4: put_char(CH_CR);
                    5: put_char(CH_BS);
                    default: put_char(CH_TAB);
                endcase
            end else if (pick < 90) begin
                read_cell(IDX_W'(last == 0 ? 0 : last - 1));
            end else if (pick < 97) begin
                read_cell(IDX_W'($urandom_range(0, CELL_COUNT - 1)));
            end else begin
                read_cell(IDX_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    task automatic test_random_mix(input int count, input logic [ATTR_W-1:0] value);
        drain_outcomes();
        set_attribute(value);
        send_random_stream(count);
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        send_random_stream(30);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_PUT;
        i_char_byte  = '0;
        i_read_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        quiet_mode     = 1'b0;
        hold_off_req   = 1'b0;
        attr_mirror    = ATTR_RESET;
        cur_row        = 0;
        cur_col        = 0;
        foreach (screen_mirror[i]) screen_mirror[i] = CELL_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_screen();
        test_control_codes();
        test_attribute_extremes();
        test_random_mix(250, 8'($urandom_range(0, 255)));
        test_backpressure();
        test_random_mix(220, 8'hFF);
        test_random_mix(30, 8'h00);
        quiet_mode = 1'b1;
        test_random_mix(220, 8'($urandom_range(0, 255)));

        drain_outcomes();
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("tb_text_terminal_char_engine_core: PASS");
        end else begin
            $display("tb_text_terminal_char_engine_core: FAIL");
        end
        $finish;
    end

endmodule
